### sv/itoa_pkg.sv
package itoa_pkg;

  // Conversion selector codes carried on the input channel.
  typedef enum logic [2:0] {
    CMD_CHAR = 3'd0,
    CMD_SDEC = 3'd1,
    CMD_UDEC = 3'd2,
    CMD_HEXL = 3'd3,
    CMD_HEXU = 3'd4,
    CMD_PTR  = 3'd5
  } cmd_t;

  // Field widths of one request and one output character.
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COUNT_W = 32;

  // Digit scratch depth and the index width it needs.
  localparam int unsigned DIGIT_DEPTH = 20;
  localparam int unsigned DIGIT_IDX_W = $clog2(DIGIT_DEPTH);

  // ceil(2^35 / 10): (v * RECIP10) >> 35 equals v / 10 for every 32-bit v.
  localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int unsigned RECIP10_SHIFT = 35;

  // Fixed characters.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X     = 8'h78;

  // Map one hex or decimal digit to its ASCII code.
  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] ch;
    begin
      if (nib < 4'd10) begin
        ch = CH_ZERO + {4'b0000, nib};
      end else if (upper) begin
        ch = 8'h37 + {4'b0000, nib};
      end else begin
        ch = 8'h57 + {4'b0000, nib};
      end
      return ch;
    end
  endfunction

endpackage

### sv/itoa_in_if.sv
interface itoa_in_if import itoa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

### sv/itoa_out_if.sv
interface itoa_out_if import itoa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  character;
  logic               last;
  logic [COUNT_W-1:0] total_count;

  modport source (output valid, output character, output last, output total_count,
                  input ready);
  modport sink   (input valid, input character, input last, input total_count,
                  output ready);
endinterface

### sv/integer_to_ascii_formatter.sv
// Integer to ASCII formatter.
// in_ch takes one conversion request per beat (cmd, value); out_ch gives one
// ASCII character per beat, most significant first, with last set on the
// final character of a request and total_count holding the running total.
// in_ch.ready is high only while the sequencer is idle; one request is
// handled at a time. A request with an undefined selector is taken and
// dropped without output.
// Digit work: hex and pointer digits each take a shift step (shift unit),
// decimal digits each take a multiply by the reciprocal of ten and a
// remainder step. Characters then leave at one per cycle while the
// receiver takes them.
// The output register holds a character until it is taken; a stall on
// out_ch halts the emit sequence but the last character of a request can
// wait there while the next request is accepted.
// Synchronous reset clears the sequencer, the output valid and the running
// total; no clearing pass is needed.
module integer_to_ascii_formatter import itoa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  itoa_in_if.sink           in_ch,
  itoa_out_if.source        out_ch
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_HEX  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  localparam logic [DIGIT_IDX_W-1:0] LAST_IDX = DIGIT_IDX_W'(DIGIT_DEPTH - 1);

  state_t                 state_r, state_nxt;
  logic [VALUE_W-1:0]     v_r, v_nxt;
  logic [63:0]            prod_r;
  logic [DIGIT_IDX_W-1:0] n_r, n_nxt;
  logic [15:0]            pfx_r, pfx_nxt;
  logic [1:0]             pfx_cnt_r, pfx_cnt_nxt;
  logic                   upper_r, upper_nxt;
  logic [3:0]             dbuf_r [DIGIT_DEPTH];
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;
  logic [COUNT_W-1:0]     count_r, count_nxt;

  logic                   accept;
  logic                   dbuf_we;
  logic [3:0]             dbuf_wdata;
  logic [28:0]            quot;
  logic [31:0]            quot_x10;
  logic [31:0]            rem_full;
  logic [31:0]            low32;
  logic [31:0]            neg32;
  logic [VALUE_W-1:0]     hex_shift;
  logic [DIGIT_IDX_W-1:0] rd_idx;
  logic                   emit_load;
  logic                   emit_last;

  assign accept = in_ch.valid && (state_r == ST_IDLE);
  assign in_ch.ready = (state_r == ST_IDLE);

  // Quotient and remainder of the decimal step from the registered product.
  assign quot     = prod_r[63:RECIP10_SHIFT];
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem_full = v_r[31:0] - quot_x10;

  assign low32     = in_ch.value[31:0];
  assign neg32     = (~low32) + 32'd1;
  assign hex_shift = v_r >> 4;
  assign rd_idx    = n_r - DIGIT_IDX_W'(1);

  // In the emit state, emit a character whenever the output register is free or being taken.
  assign emit_load = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign emit_last = ((pfx_cnt_r == 2'd1) && (n_r == '0)) ||
                     ((pfx_cnt_r == 2'd0) && (n_r == DIGIT_IDX_W'(1)));

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_nxt     = state_r;
    v_nxt         = v_r;
    n_nxt         = n_r;
    pfx_nxt       = pfx_r;
    pfx_cnt_nxt   = pfx_cnt_r;
    upper_nxt     = upper_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    count_nxt     = count_r;
    dbuf_we       = 1'b0;
    dbuf_wdata    = rem_full[3:0];

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          n_nxt       = '0;
          pfx_nxt     = 16'h0000;
          pfx_cnt_nxt = 2'd0;
          upper_nxt   = 1'b0;
          v_nxt       = {32'd0, low32};
          case (in_ch.cmd)
            CMD_CHAR: begin
              pfx_nxt     = {in_ch.value[7:0], 8'h00};
              pfx_cnt_nxt = 2'd1;
              state_nxt   = ST_EMIT;
            end
            CMD_SDEC: begin
              if (low32[31]) begin
                pfx_nxt     = {CH_MINUS, 8'h00};
                pfx_cnt_nxt = 2'd1;
                v_nxt       = {32'd0, neg32};
              end
              state_nxt = ST_MUL;
            end
            CMD_UDEC: begin
              state_nxt = ST_MUL;
            end
            CMD_HEXL: begin
              state_nxt = ST_HEX;
            end
            CMD_HEXU: begin
              upper_nxt = 1'b1;
              state_nxt = ST_HEX;
            end
            CMD_PTR: begin
              pfx_nxt     = {CH_ZERO, CH_X};
              pfx_cnt_nxt = 2'd2;
              v_nxt       = in_ch.value;
              state_nxt   = ST_HEX;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // Store one decimal digit and carry the quotient on.
        dbuf_we    = 1'b1;
        dbuf_wdata = rem_full[3:0];
        v_nxt      = {35'd0, quot};
        n_nxt      = n_r + DIGIT_IDX_W'(1);
        if ((quot == '0) || (n_r == LAST_IDX)) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_HEX: begin
        // Store one nibble and shift the value down.
        dbuf_we    = 1'b1;
        dbuf_wdata = v_r[3:0];
        v_nxt      = hex_shift;
        n_nxt      = n_r + DIGIT_IDX_W'(1);
        if ((hex_shift == '0) || (n_r == LAST_IDX)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = emit_last;
          count_nxt     = count_r + COUNT_W'(1);
          if (pfx_cnt_r != 2'd0) begin
            out_char_nxt = pfx_r[15:8];
            pfx_nxt      = {pfx_r[7:0], 8'h00};
            pfx_cnt_nxt  = pfx_cnt_r - 2'd1;
          end else begin
            out_char_nxt = digit_char(dbuf_r[rd_idx], upper_r);
            n_nxt        = rd_idx;
          end
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  // Payload registers and the shared reciprocal multiplier.
  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    n_r        <= n_nxt;
    pfx_r      <= pfx_nxt;
    pfx_cnt_r  <= pfx_cnt_nxt;
    upper_r    <= upper_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    prod_r     <= {32'd0, v_r[31:0]} * {32'd0, RECIP10};
    if (dbuf_we) begin
      dbuf_r[n_r] <= dbuf_wdata;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.character   = out_char_r;
  assign out_ch.last        = out_last_r;
  assign out_ch.total_count = count_r;

endmodule

### bench/integer_to_ascii_formatter_test.sv
`timescale 1ns / 1ps

module integer_to_ascii_formatter_test;
  import itoa_pkg::*;

  // Selector codes the block must take and drop without output.
  localparam logic [CMD_W-1:0] CMD_UNDEF_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNDEF_7 = 3'd7;

  localparam int unsigned MAX_GAP      = 17;
  localparam int unsigned MAX_DIGITS   = 20;
  localparam int unsigned SETTLE_TICKS = 60;
  localparam int unsigned RANDOM_ITEMS = 160;

  // One expected character beat on the result channel.
  typedef struct packed {
    logic [CHAR_W-1:0]  character;
    logic               last;
    logic [COUNT_W-1:0] total_count;
  } char_beat_t;

  logic clk;
  logic rst_n;

  itoa_in_if  in_ch ();
  itoa_out_if out_ch ();

  integer_to_ascii_formatter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  char_beat_t         expected_chars [$];
  logic [COUNT_W-1:0] chars_emitted;
  int unsigned        error_count;
  bit                 in_idle;
  bit                 out_idle;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog for a hung run.
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int unsigned draw_gap(input bit enabled);
    return enabled ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [3:0] d, input logic upper);
    if (d < 4'd10) return CH_ZERO + {4'b0000, d};
    return (upper ? 8'h41 : 8'h61) + {4'b0000, d} - 8'd10;
  endfunction

  // Work out the characters that one conversion request produces and queue them.
  task automatic format_request(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] magnitude;
    logic [31:0]        low_word;
    logic [4:0]         base;
    logic               upper;
    logic [3:0]         digits [0:MAX_DIGITS-1];
    int                 n;
    logic [CHAR_W-1:0]  text [$];
    char_beat_t         beat;
    low_word  = value[31:0];
    magnitude = {32'd0, low_word};
    base      = 5'd0;
    upper     = 1'b0;
    n         = 0;
    case (cmd)
      CMD_CHAR: text.push_back(value[7:0]);
      CMD_SDEC: begin
        if (low_word[31]) begin
          text.push_back(CH_MINUS);
          magnitude = {32'd0, ~low_word + 32'd1};
        end
        base = 5'd10;
      end
      CMD_UDEC: base = 5'd10;
      CMD_HEXL: base = 5'd16;
      CMD_HEXU: begin
        base  = 5'd16;
        upper = 1'b1;
      end
      CMD_PTR: begin
        text.push_back(CH_ZERO);
        text.push_back(CH_X);
        magnitude = value;
        base      = 5'd16;
      end
      default: ;
    endcase
    // Digits come out least significant first and are sent in reverse.
    if (base != 5'd0) begin
      do begin
        digits[n] = 4'(magnitude % {59'd0, base});
        magnitude = magnitude / {59'd0, base};
        n++;
      end while (magnitude != '0 && n < MAX_DIGITS);
      for (int i = n - 1; i >= 0; i--) text.push_back(digit_to_ascii(digits[i], upper));
    end
    foreach (text[i]) begin
      chars_emitted    = chars_emitted + 1;
      beat.character   = text[i];
      beat.last        = (i == text.size() - 1);
      beat.total_count = chars_emitted;
      expected_chars.push_back(beat);
    end
  endtask

  task automatic check_field(input string field, input logic [COUNT_W-1:0] want,
                             input logic [COUNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      error_count++;
    end
  endtask

  // Predict on every accepted request beat and check every accepted character beat.
  always @(posedge clk) begin
    char_beat_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) format_request(in_ch.cmd, in_ch.value);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected character, expected none, actual %0h last %0b count %0h",
                   $time, out_ch.character, out_ch.last, out_ch.total_count);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          check_field("character", COUNT_W'(want.character), COUNT_W'(out_ch.character));
          check_field("last", COUNT_W'(want.last), COUNT_W'(out_ch.last));
          check_field("total_count", want.total_count, out_ch.total_count);
        end
      end
    end
  end

  // Receiver: while idling is on, stall a random number of cycles before taking each beat.
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = draw_gap(out_idle);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Send one request beat. Called at a falling edge; returns at a falling edge
  // with valid still high so that a back-to-back beat needs no extra toggle.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value);
    int unsigned gap;
    gap = draw_gap(in_idle);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Stop sending and hold off until every queued character has arrived.
  task automatic wait_for_all_chars();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_chars.size() != 0);
    @(negedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: v[31:0] = $urandom_range(0, 99);
      1: v[31:0] = -$urandom_range(1, 99);
      2: v = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0, $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0};
      3: v = 64'd1 << $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_characters();
    send_request(CMD_CHAR, 64'h0);
    send_request(CMD_CHAR, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(CMD_CHAR, 64'h1234_5678_9ABC_DE41);
    send_request(CMD_CHAR, 64'h80);
  endtask

  task automatic test_signed_decimal();
    send_request(CMD_SDEC, 64'h0);
    send_request(CMD_SDEC, 64'hFFFF_FFFF);
    send_request(CMD_SDEC, 64'h8000_0000);
    send_request(CMD_SDEC, 64'h7FFF_FFFF);
    send_request(CMD_SDEC, 64'hDEAD_BEEF_0000_3039);
  endtask

  task automatic test_unsigned_decimal();
    send_request(CMD_UDEC, 64'h0);
    send_request(CMD_UDEC, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(CMD_UDEC, 64'h8000_0000);
  endtask

  task automatic test_hex();
    send_request(CMD_HEXL, 64'h0);
    send_request(CMD_HEXL, 64'hDEAD_BEEF);
    send_request(CMD_HEXL, 64'h1234_5678_FFFF_FFFF);
    send_request(CMD_HEXU, 64'hABCD_EF01);
    send_request(CMD_HEXU, 64'hFFFF_FFFF_0000_0000);
    send_request(CMD_HEXU, 64'hFFFF_FFFF);
  endtask

  task automatic test_pointer();
    send_request(CMD_PTR, 64'h0);
    send_request(CMD_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(CMD_PTR, 64'h8000_0000_0000_0000);
    send_request(CMD_PTR, 64'h0123_4567_89AB_CDEF);
  endtask

  // Undefined selectors are taken and dropped; the total must not move.
  task automatic test_undefined_selectors();
    send_request(CMD_UNDEF_6, random_value());
    send_request(CMD_UNDEF_7, random_value());
    send_request(CMD_HEXL, 64'h5);
  endtask

  // Random requests with idling switched on and off in stretches, and one pause
  // halfway through that lets the block run dry before sending resumes.
  task automatic test_random_requests(input int unsigned count);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < count) begin
      if (sent % 20 == 0) begin
        in_idle  = $urandom_range(0, 3) != 0;
        out_idle = $urandom_range(0, 3) != 0;
      end
      if (sent == count / 2) wait_for_all_chars();
      pick = $urandom_range(0, 19);
      if (pick == 19) begin
        send_request($urandom_range(0, 1) ? CMD_UNDEF_6 : CMD_UNDEF_7, random_value());
      end else begin
        send_request(CMD_W'(pick % 6), random_value());
        sent++;
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_CHAR;
    in_ch.value   = '0;
    chars_emitted = '0;
    error_count   = 0;
    in_idle       = 1'b1;
    out_idle      = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_characters();
    test_signed_decimal();
    test_unsigned_decimal();
    test_hex();
    test_pointer();
    test_undefined_selectors();
    test_random_requests(RANDOM_ITEMS);

    wait_for_all_chars();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
